FILE: design/sma_pkg.sv
// Shared types and codes for the stack machine ALU.
`timescale 1ns / 1ps
`default_nettype none

package sma_pkg;

    localparam int WORD_W   = 32;
    localparam int MODE_W   = 4;
    localparam int STATUS_W = 3;

    // opcodes
    localparam logic [MODE_W-1:0] OP_PUSH = 4'd0;
    localparam logic [MODE_W-1:0] OP_POP  = 4'd1;
    localparam logic [MODE_W-1:0] OP_MOVE = 4'd2;
    localparam logic [MODE_W-1:0] OP_ADD  = 4'd3;
    localparam logic [MODE_W-1:0] OP_SUB  = 4'd4;
    localparam logic [MODE_W-1:0] OP_MUL  = 4'd5;
    localparam logic [MODE_W-1:0] OP_DIV  = 4'd6;
    localparam logic [MODE_W-1:0] OP_MOD  = 4'd7;
    localparam logic [MODE_W-1:0] OP_LOG  = 4'd8;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVER    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZ    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic clear_step;
        logic latch_in;
        logic set_status;
        logic do_push;
        logic set_sp;
        logic load_top;
        logic rd_a;
        logic load_a;
        logic exec;
        logic div_start;
        logic div_take;
        logic write_back;
        logic load_out;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [STATUS_W-1:0] err;
        logic                cls_push;
        logic                cls_spset;
        logic                cls_binop;
        logic                cls_div;
        logic                clr_last;
        logic                div_done;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: design/sma_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/sma_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
`default_nettype none

module sma_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [sma_pkg::WORD_W-1:0] i_dividend,
    input  wire logic [sma_pkg::WORD_W-1:0] i_divisor,
    input  wire logic                      i_want_rem,
    output      logic                      o_done,
    output      logic [sma_pkg::WORD_W-1:0] o_result
);

    localparam int W  = sma_pkg::WORD_W;
    localparam int CW = $clog2(W);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_ub;
    logic          r_na;
    logic          r_nb;
    logic          r_want_rem;

    logic [W:0]    rem_sh;
    logic [W+1:0]  diff;
    logic          neg;

    assign rem_sh = {r_rem, r_quo[W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_ub};
    assign neg    = diff[W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_na       <= i_dividend[W-1];
            r_nb       <= i_divisor[W-1];
            r_want_rem <= i_want_rem;
            r_rem      <= '0;
            r_quo      <= i_dividend[W-1] ? (~i_dividend + W'(1)) : i_dividend;
            r_ub       <= i_divisor[W-1] ? (~i_divisor + W'(1)) : i_divisor;
        end else if (r_busy) begin
            r_rem <= neg ? rem_sh[W-1:0] : diff[W-1:0];
            r_quo <= {r_quo[W-2:0], ~neg};
        end
    end

    always_comb begin
        if (r_want_rem) begin
            o_result = r_na ? (~r_rem + W'(1)) : r_rem;
        end else begin
            o_result = (r_na ^ r_nb) ? (~r_quo + W'(1)) : r_quo;
        end
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

FILE: design/sma_datapath.sv
// Datapath: stack store, stack pointer, cached top, ALU, divider and result register.
`timescale 1ns / 1ps
`default_nettype none

module sma_datapath #(
    parameter int STACK_DEPTH = 256
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire sma_pkg::t_dp_cmd                      i_cmd,
    output      sma_pkg::t_dp_stat                     o_stat,
    input  wire logic [sma_pkg::MODE_W-1:0]            i_mode,
    input  wire logic [sma_pkg::WORD_W-1:0]            i_operand,
    output      logic [sma_pkg::STATUS_W-1:0]          o_status,
    output      logic [sma_pkg::WORD_W-1:0]            o_top_value,
    output      logic [$clog2(STACK_DEPTH+1)-1:0]      o_depth
);

    localparam int W  = sma_pkg::WORD_W;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam logic [DW-1:0] DEPTH_D  = DW'(STACK_DEPTH);
    localparam logic [W-1:0]  DEPTH_W  = W'(STACK_DEPTH);
    localparam logic [AW-1:0] LAST_A   = AW'(STACK_DEPTH - 1);
    localparam logic [DW-1:0] ONE_D    = DW'(1);
    localparam logic [DW-1:0] TWO_D    = DW'(2);

    logic [sma_pkg::MODE_W-1:0]   r_mode;
    logic [W-1:0]                 r_operand;
    logic [DW-1:0]                r_sp;
    logic [W-1:0]                 r_top;
    logic [W-1:0]                 r_a;
    logic [W-1:0]                 r_res;
    logic [sma_pkg::STATUS_W-1:0] r_status;
    logic [AW-1:0]                r_clr_addr;
    logic [sma_pkg::STATUS_W-1:0] r_o_status;
    logic [W-1:0]                 r_o_top;
    logic [DW-1:0]                r_o_depth;

    logic [DW-1:0] new_sp;
    logic [DW-1:0] new_sp_m1;
    logic [DW-1:0] sp_m1;
    logic [DW-1:0] sp_m2;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [W-1:0]  mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [W-1:0]  mem_rdata;
    logic          div_done;
    logic [W-1:0]  div_result;

    assign sp_m1     = r_sp - ONE_D;
    assign sp_m2     = r_sp - TWO_D;
    assign new_sp    = (r_mode == sma_pkg::OP_MOVE) ? r_operand[DW-1:0] : sp_m1;
    assign new_sp_m1 = new_sp - ONE_D;

    // error checks and opcode class for the latched request
    always_comb begin
        o_stat           = '0;
        o_stat.clr_last  = (r_clr_addr == LAST_A);
        o_stat.div_done  = div_done;
        o_stat.err       = sma_pkg::ST_OK;
        unique case (r_mode)
            sma_pkg::OP_PUSH: begin
                o_stat.cls_push = 1'b1;
                if (r_sp >= DEPTH_D) o_stat.err = sma_pkg::ST_OVER;
            end
            sma_pkg::OP_POP: begin
                o_stat.cls_spset = 1'b1;
                if (r_sp == '0) o_stat.err = sma_pkg::ST_UNDER;
            end
            sma_pkg::OP_MOVE: begin
                o_stat.cls_spset = 1'b1;
                if (r_operand[W-1] || (r_operand > DEPTH_W)) o_stat.err = sma_pkg::ST_OVER;
            end
            sma_pkg::OP_ADD, sma_pkg::OP_SUB, sma_pkg::OP_MUL: begin
                o_stat.cls_binop = 1'b1;
                if (r_sp < TWO_D) o_stat.err = sma_pkg::ST_UNDER;
            end
            sma_pkg::OP_DIV, sma_pkg::OP_MOD: begin
                o_stat.cls_binop = 1'b1;
                o_stat.cls_div   = 1'b1;
                if (r_sp < TWO_D) begin
                    o_stat.err = sma_pkg::ST_UNDER;
                end else if (r_top == '0) begin
                    o_stat.err = sma_pkg::ST_DIVZ;
                end
            end
            sma_pkg::OP_LOG: begin
                o_stat.err = sma_pkg::ST_OK;
            end
            default: begin
                o_stat.err = sma_pkg::ST_UNKNOWN;
            end
        endcase
    end

    // single write port shared by the clear pass, push and write-back
    always_comb begin
        mem_we    = i_cmd.clear_step | i_cmd.do_push | i_cmd.write_back;
        mem_waddr = sp_m2[AW-1:0];
        mem_wdata = r_res;
        priority if (i_cmd.clear_step) begin
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else if (i_cmd.do_push) begin
            mem_waddr = r_sp[AW-1:0];
            mem_wdata = r_operand;
        end else begin
            mem_waddr = sp_m2[AW-1:0];
            mem_wdata = r_res;
        end
    end

    assign mem_raddr = i_cmd.rd_a ? sp_m2[AW-1:0] : new_sp_m1[AW-1:0];

    sma_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    sma_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_a),
        .i_divisor  (r_top),
        .i_want_rem (r_mode == sma_pkg::OP_MOD),
        .o_done     (div_done),
        .o_result   (div_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp       <= '0;
            r_top      <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.clear_step) r_clr_addr <= r_clr_addr + AW'(1);
            if (i_cmd.do_push) begin
                r_sp  <= r_sp + ONE_D;
                r_top <= r_operand;
            end
            if (i_cmd.set_sp) r_sp <= new_sp;
            // r_sp already holds the new depth here
            if (i_cmd.load_top) r_top <= (r_sp == '0) ? '0 : mem_rdata;
            if (i_cmd.write_back) begin
                r_sp  <= sp_m1;
                r_top <= r_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_mode    <= i_mode;
            r_operand <= i_operand;
        end
        if (i_cmd.set_status) r_status <= o_stat.err;
        if (i_cmd.load_a) r_a <= mem_rdata;
        if (i_cmd.exec) begin
            unique case (r_mode)
                sma_pkg::OP_ADD: r_res <= r_a + r_top;
                sma_pkg::OP_SUB: r_res <= r_a - r_top;
                sma_pkg::OP_MUL: r_res <= r_a * r_top;
                default:         r_res <= r_res;
            endcase
        end
        if (i_cmd.div_take) r_res <= div_result;
        if (i_cmd.load_out) begin
            r_o_status <= r_status;
            r_o_top    <= r_top;
            r_o_depth  <= r_sp;
        end
    end

    assign o_status    = r_o_status;
    assign o_top_value = r_o_top;
    assign o_depth     = r_o_depth;

endmodule

`default_nettype wire

FILE: design/sma_ctrl.sv
// Controller state machine: request handshake, instruction sequencing, result handshake.
`timescale 1ns / 1ps
`default_nettype none

module sma_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output      logic              o_in_stall,
    output      logic              o_out_valid,
    input  wire logic              i_out_stall,
    output      sma_pkg::t_dp_cmd  o_cmd,
    input  wire sma_pkg::t_dp_stat i_stat
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_RDTOP  = 4'd3;
    localparam logic [3:0] S_WAIT_A = 4'd4;
    localparam logic [3:0] S_EXEC   = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_WB     = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.set_status = 1'b1;
                priority if (i_stat.err != sma_pkg::ST_OK) begin
                    n_state = S_DONE;
                end else if (i_stat.cls_push) begin
                    o_cmd.do_push = 1'b1;
                    n_state       = S_DONE;
                end else if (i_stat.cls_spset) begin
                    o_cmd.set_sp = 1'b1;
                    n_state      = S_RDTOP;
                end else if (i_stat.cls_binop) begin
                    o_cmd.rd_a = 1'b1;
                    n_state    = S_WAIT_A;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RDTOP: begin
                o_cmd.load_top = 1'b1;
                n_state        = S_DONE;
            end
            S_WAIT_A: begin
                o_cmd.load_a = 1'b1;
                n_state      = S_EXEC;
            end
            S_EXEC: begin
                if (i_stat.cls_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_WB;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_state        = S_WB;
                end
            end
            S_WB: begin
                o_cmd.write_back = 1'b1;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: design/stack_machine_alu_unit.sv
// Push, log and any error go through decode to completion; pop and move also reload the top;
// add, sub and mul read the second operand, execute and write back; div and mod start the
// 32-step shared divider and wait for it before write-back. One request is in flight at a
// time; the next is taken once the result is loaded into the output register, a load that
// waits while the result side stalls. Reset (synchronous, active low) empties the stack, then
// a clearing pass zeroes every entry of the stack store, during which no request is taken.
`timescale 1ns / 1ps
`default_nettype none

module stack_machine_alu_unit #(
    parameter int STACK_DEPTH = 256
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_in_valid,
    output      logic                                    o_in_stall,
    input  wire logic        [sma_pkg::MODE_W-1:0]       i_mode,
    input  wire logic signed [sma_pkg::WORD_W-1:0]       i_operand,
    output      logic                                    o_out_valid,
    input  wire logic                                    i_out_stall,
    output      logic        [sma_pkg::STATUS_W-1:0]     o_status,
    output      logic signed [sma_pkg::WORD_W-1:0]       o_top_value,
    output      logic        [$clog2(STACK_DEPTH+1)-1:0] o_depth
);

    sma_pkg::t_dp_cmd  cmd;
    sma_pkg::t_dp_stat stat;

    sma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    sma_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_mode      (i_mode),
        .i_operand   (i_operand),
        .o_status    (o_status),
        .o_top_value (o_top_value),
        .o_depth     (o_depth)
    );

endmodule

`default_nettype wire
